@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the half-step homing controller RTL.
// Depends on nothing; every user supplies aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SHHC_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SHHC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/shhc_pkg.sv @@
// Package for the half-step homing controller: payload and config structs,
// field codes, register indexes and the coil table. Depends on nothing.
package shhc_pkg;

    localparam int STEP_PHASES       = 8;
    localparam int PHASE_WIDTH       = $clog2(STEP_PHASES);
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int CFG_WIDTH         = 16;
    localparam int FIELD_CNT_WIDTH   = 16;

    localparam logic [CFG_WIDTH-1:0] HOMING_COUNT_RST = 16'd100;
    localparam logic [CFG_WIDTH-1:0] BASE_OPEN_RST    = 16'd20;

    // Config register indexes
    localparam logic REG_HOMING_COUNT = 1'b0;
    localparam logic REG_BASE_OPEN    = 1'b1;

    // Item kinds
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_MOVE = 2'd1;
    localparam logic [1:0] FUNC_HOME = 2'd2;

    // Direction codes
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_OPEN  = 2'd1;
    localparam logic [1:0] DIR_CLOSE = 2'd2;

    typedef enum logic [1:0] {
        HP_NONE  = 2'd0,
        HP_CLOSE = 2'd1,
        HP_OPEN  = 2'd2
    } shhc_hphase_t;

    typedef struct packed {
        logic [1:0]                 func;
        logic [FIELD_CNT_WIDTH-1:0] step_count;
        logic [1:0]                 direction;
    } shhc_in_t;

    typedef struct packed {
        logic [3:0]             coil_pattern;
        logic [PHASE_WIDTH-1:0] phase_index;
        logic                   busy_res;
        logic                   homed;
    } shhc_out_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] homing_step_count;
        logic [CFG_WIDTH-1:0] base_open_steps;
    } shhc_cfg_t;

    // Half-step order w1, w1+w2, w2, w2+w4, w4, w4+w3, w3, w3+w1
    function automatic logic [3:0] coil_lookup(input logic [PHASE_WIDTH-1:0] pos);
        logic [3:0] pat;
        unique case (pos)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'hA;
            3'd4:    pat = 4'h8;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h4;
            default: pat = 4'h5;
        endcase
        return pat;
    endfunction

endpackage

@@ hw/rtl/shhc_core.sv @@
// Motion state of the half-step homing controller: position, step counter,
// direction, homing phase and flags. Depends on shhc_pkg and assert_macros.svh.
module shhc_core #(
    parameter int COUNT_WIDTH = shhc_pkg::COUNT_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_en,
    input  shhc_pkg::shhc_in_t  item,
    input  shhc_pkg::shhc_cfg_t cfg,
    output shhc_pkg::shhc_out_t result
);
    import shhc_pkg::*;

    logic [PHASE_WIDTH-1:0] position_reg, position_next;
    logic [COUNT_WIDTH-1:0] steps_reg, steps_next;
    logic [1:0]             dir_reg, dir_next;
    logic                   active_reg, active_next;
    shhc_hphase_t           hphase_reg, hphase_next;
    logic                   homed_reg, homed_next;

    logic [PHASE_WIDTH-1:0] pos_stepped;
    logic [COUNT_WIDTH-1:0] steps_dec;

    always_comb begin
        unique case (dir_reg)
            DIR_OPEN:  pos_stepped = position_reg + PHASE_WIDTH'(1);
            DIR_CLOSE: pos_stepped = position_reg - PHASE_WIDTH'(1);
            default:   pos_stepped = position_reg;
        endcase
        steps_dec = (steps_reg != '0) ? steps_reg - COUNT_WIDTH'(1) : steps_reg;
    end

    always_comb begin
        position_next = position_reg;
        steps_next    = steps_reg;
        dir_next      = dir_reg;
        active_next   = active_reg;
        hphase_next   = hphase_reg;
        homed_next    = homed_reg;
        if (item_en) begin
            unique case (item.func)
                FUNC_TICK: begin
                    if (active_reg) begin
                        position_next = pos_stepped;
                        steps_next    = steps_dec;
                        if (steps_dec == '0) begin
                            unique case (hphase_reg)
                                HP_CLOSE: begin
                                    steps_next  = COUNT_WIDTH'(cfg.base_open_steps);
                                    dir_next    = DIR_OPEN;
                                    hphase_next = HP_OPEN;
                                end
                                HP_OPEN: begin
                                    hphase_next = HP_NONE;
                                    homed_next  = 1'b1;
                                    active_next = 1'b0;
                                end
                                default: begin
                                    dir_next    = DIR_NONE;
                                    active_next = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                FUNC_MOVE: begin
                    steps_next  = COUNT_WIDTH'(item.step_count);
                    dir_next    = item.direction;
                    active_next = 1'b1;
                end
                FUNC_HOME: begin
                    hphase_next = HP_CLOSE;
                    steps_next  = COUNT_WIDTH'(cfg.homing_step_count);
                    dir_next    = DIR_CLOSE;
                    active_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            steps_reg    <= '0;
            dir_reg      <= DIR_NONE;
            active_reg   <= 1'b0;
            hphase_reg   <= HP_NONE;
            homed_reg    <= 1'b0;
        end else begin
            position_reg <= position_next;
            steps_reg    <= steps_next;
            dir_reg      <= dir_next;
            active_reg   <= active_next;
            hphase_reg   <= hphase_next;
            homed_reg    <= homed_next;
        end
    end

    // Result reflects the state after this item's update
    always_comb begin
        result.coil_pattern = coil_lookup(position_next);
        result.phase_index  = position_next;
        result.busy_res     = active_next;
        result.homed        = homed_next;
    end

`include "assert_macros.svh"
    `SHHC_ASSERT_NEXT(a_homed_sticky, homed_reg, homed_reg)
    `SHHC_ASSERT_NOW(a_idle_not_homing, !active_reg, hphase_reg == HP_NONE)
    `SHHC_ASSERT_NEXT(a_idle_tick_holds, item_en && item.func == FUNC_TICK && !active_reg,
        $stable(position_reg) && $stable(steps_reg))

endmodule

@@ hw/rtl/stepper_half_step_homing_ctrl.sv @@
// Top level of the half-step homing controller: config registers, output
// register with skid stage, and the motion core. Depends on shhc_pkg,
// shhc_core and assert_macros.svh.
//
// Drives a four-winding unipolar stepper through the eight half-step
// positions. Each transfer on the s_ channel is a tick, a move request or a
// home request, and each one yields exactly one transfer on the m_ channel
// carrying the coil pattern, the position and the busy and homed flags after
// that item has taken effect. While s_ready is high the block takes one item
// per clock: the state update is a single short pass from the accepted item
// to the state and result registers, so the next item is accepted in the
// following cycle. An output register plus a one-entry skid stage keep
// s_ready high while a result waits; s_ready drops only when both are full.
// A result appears on m_ the cycle after its item is accepted when the
// output register is free; otherwise it waits in the skid stage until the
// result ahead of it leaves. Write homing_step_count (index 0) and
// base_open_steps (index 1) through the cfg port while no run is active.
module stepper_half_step_homing_ctrl #(
    parameter int COUNT_WIDTH = shhc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  shhc_pkg::shhc_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output shhc_pkg::shhc_out_t             m_data,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [shhc_pkg::CFG_WIDTH-1:0]  cfg_wdata
);
    import shhc_pkg::*;

    shhc_cfg_t cfg_reg;
    shhc_out_t result;
    shhc_out_t m_data_reg, m_data_next;
    shhc_out_t skid_data_reg, skid_data_next;
    logic      m_valid_reg, m_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    logic      s_accept;

    // Config: write straight into the selected register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.homing_step_count <= HOMING_COUNT_RST;
            cfg_reg.base_open_steps   <= BASE_OPEN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HOMING_COUNT: cfg_reg.homing_step_count <= cfg_wdata;
                REG_BASE_OPEN:    cfg_reg.base_open_steps   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Accept whenever the skid stage is free
    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    shhc_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (s_accept),
        .item    (s_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Output register fed from the skid first, then from the core;
    // park a fresh result in the skid while the output is stalled.
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = s_accept;
                m_data_next  = result;
            end
        end else if (s_accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload holds without reset
    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`include "assert_macros.svh"
    `SHHC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, m_valid_reg)
    `SHHC_ASSERT_NEXT(a_stall_parks, s_accept && m_valid_reg && !m_ready,
        skid_valid_reg && m_valid_reg)
    `SHHC_ASSERT_NEXT(a_accept_shows, s_accept && !skid_valid_reg, m_valid_reg)

endmodule

@@ dv/stepper_half_step_homing_ctrl_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for stepper_half_step_homing_ctrl: random and directed ticks, moves and
// home requests, with a scoreboard class that predicts each result. Depends on shhc_pkg.

module stepper_half_step_homing_ctrl_test;
    import shhc_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [1:0] DIR_SPARE  = 2'd3;

    // Half-step coil order, position 0 in the low nibble: 1,3,2,A,8,C,4,5
    localparam logic [31:0] COIL_SEQ = 32'h54C8_A231;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 203;
    localparam int LONG_HOLD   = 200;
    localparam int MAX_REPORTS = 100;

    // Motion predictor plus the queue of results it still owes the m_ channel.
    class half_step_scoreboard;
        logic [CFG_WIDTH-1:0] homing_count;
        logic [CFG_WIDTH-1:0] base_open;
        logic [2:0]           position;
        logic [15:0]          remaining;
        logic [1:0]           move_dir;
        logic                 running;
        shhc_hphase_t         hphase;
        logic                 homed_flag;
        shhc_out_t            expected_q[$];
        int                   errors;

        function new();
            homing_count = 16'd100;
            base_open    = 16'd20;
            position     = 3'd0;
            remaining    = 16'd0;
            move_dir     = DIR_NONE;
            running      = 1'b0;
            hphase       = HP_NONE;
            homed_flag   = 1'b0;
            errors       = 0;
        endfunction

        function void set_register(logic idx, logic [CFG_WIDTH-1:0] val);
            if (idx == REG_HOMING_COUNT) begin
                homing_count = val;
            end else begin
                base_open = val;
            end
        endfunction

        function void note_item(shhc_in_t item);
            shhc_out_t res;
            case (item.func)
                FUNC_TICK: begin
                    if (running) begin
                        if (move_dir == DIR_OPEN) begin
                            position = position + 3'd1;
                        end else if (move_dir == DIR_CLOSE) begin
                            position = position - 3'd1;
                        end
                        if (remaining != 16'd0) begin
                            remaining = remaining - 16'd1;
                        end
                        if (remaining == 16'd0) begin
                            if (hphase == HP_CLOSE) begin
                                remaining = base_open;
                                move_dir  = DIR_OPEN;
                                hphase    = HP_OPEN;
                            end else if (hphase == HP_OPEN) begin
                                hphase     = HP_NONE;
                                homed_flag = 1'b1;
                                running    = 1'b0;
                            end else begin
                                move_dir = DIR_NONE;
                                running  = 1'b0;
                            end
                        end
                    end
                end
                FUNC_MOVE: begin
                    remaining = item.step_count;
                    move_dir  = item.direction;
                    running   = 1'b1;
                end
                FUNC_HOME: begin
                    hphase    = HP_CLOSE;
                    remaining = homing_count;
                    move_dir  = DIR_CLOSE;
                    running   = 1'b1;
                end
                default: ;
            endcase
            res.coil_pattern = COIL_SEQ[{position, 2'b00} +: 4];
            res.phase_index  = position;
            res.busy_res     = running;
            res.homed        = homed_flag;
            expected_q.push_back(res);
        endfunction

        function void report(string what, logic [3:0] want, logic [3:0] got);
            errors++;
            // Stop printing after many mismatches; keep counting
            if (errors <= MAX_REPORTS) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            end
        endfunction

        function void check_result(shhc_out_t got);
            shhc_out_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, got);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.coil_pattern !== want.coil_pattern) begin
                report("coil_pattern", want.coil_pattern, got.coil_pattern);
            end
            if (got.phase_index !== want.phase_index) begin
                report("phase_index", 4'(want.phase_index), 4'(got.phase_index));
            end
            if (got.busy_res !== want.busy_res) begin
                report("busy_res", 4'(want.busy_res), 4'(got.busy_res));
            end
            if (got.homed !== want.homed) begin
                report("homed", 4'(want.homed), 4'(got.homed));
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    shhc_in_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    shhc_out_t            m_data;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;

    half_step_scoreboard sb;

    // Idle bounds for each side; zero gives back-to-back stretches
    int unsigned send_idle_max = 15;
    int unsigned recv_idle_max = 15;
    // Set by the stimulus to make the receiver hold off once for the LONG_HOLD stall
    bit          hold_outputs  = 1'b0;

    stepper_half_step_homing_ctrl dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic shhc_in_t make_item(logic [1:0] f, logic [15:0] c, logic [1:0] d);
        shhc_in_t it;
        it.func       = f;
        it.step_count = c;
        it.direction  = d;
        return it;
    endfunction

    // Mostly ticks so that runs and homing sequences finish; the rest are
    // moves, home requests, the spare code and fully random items.
    function automatic shhc_in_t random_item();
        shhc_in_t    it;
        int unsigned pick;
        it.func       = FUNC_TICK;
        it.step_count = 16'($urandom);
        it.direction  = 2'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            it.func = FUNC_MOVE;
            case ($urandom_range(0, 9))
                0:       it.step_count = 16'd0;
                1:       it.step_count = 16'hFFFF;
                2, 3:    it.step_count = 16'($urandom);
                default: it.step_count = 16'($urandom_range(1, 12));
            endcase
            if ($urandom_range(0, 9) < 8) begin
                it.direction = $urandom_range(0, 1) ? DIR_OPEN : DIR_CLOSE;
            end else begin
                it.direction = $urandom_range(0, 1) ? DIR_NONE : DIR_SPARE;
            end
        end else if (pick < 28) begin
            it.func = FUNC_HOME;
        end else if (pick < 33) begin
            it.func = FUNC_SPARE;
        end else if (pick < 40) begin
            it.func = 2'($urandom);
        end
        return it;
    endfunction

    // Offer one item after a random gap; hold valid and payload until the transfer.
    task automatic send_item(input shhc_in_t item);
        int unsigned gap;
        gap = $urandom_range(0, send_idle_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(item);
    endtask

    // Drop valid and wait until every predicted result has been checked.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    // Bring the block to rest: two zero-count runs end any move, and carry a
    // homing sequence through both of its phases.
    task automatic settle_idle();
        send_item(make_item(FUNC_MOVE, 16'd0, DIR_NONE));
        send_item(make_item(FUNC_TICK, 16'd0, DIR_NONE));
        send_item(make_item(FUNC_MOVE, 16'd0, DIR_NONE));
        send_item(make_item(FUNC_TICK, 16'd0, DIR_NONE));
        wait_drained();
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_register(idx, val);
        @(posedge aclk);
    endtask

    // Directed items at the reset register values.
    task automatic run_directed();
        send_item(make_item(FUNC_TICK,  16'hFFFF, DIR_SPARE)); // tick while idle
        send_item(make_item(FUNC_SPARE, 16'hFFFF, DIR_SPARE)); // spare code changes nothing
        send_item(make_item(FUNC_MOVE,  16'd0,    DIR_OPEN));  // zero count still steps once
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));
        send_item(make_item(FUNC_MOVE,  16'hFFFF, DIR_CLOSE)); // largest count, close wraps
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));
        send_item(make_item(FUNC_MOVE,  16'd1,    DIR_SPARE)); // spare direction: no motion
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));
        send_item(make_item(FUNC_MOVE,  16'd3,    DIR_NONE));
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));
        send_item(make_item(FUNC_HOME,  16'd0,    DIR_NONE));  // homing phase toward close
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));
        send_item(make_item(FUNC_MOVE,  16'd0,    DIR_NONE));  // move during homing
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));  // switch to the open phase
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));
        send_item(make_item(FUNC_MOVE,  16'd1,    DIR_OPEN));
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));  // homing done
        send_item(make_item(FUNC_HOME,  16'd0,    DIR_NONE));  // home again while homed
        send_item(make_item(FUNC_TICK,  16'd0,    DIR_NONE));
    endtask

    // Receiver: draw a stall per result, or hold off long when asked.
    initial begin
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_outputs) begin
                hold_outputs = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = $urandom_range(0, recv_idle_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
        end
    end

    // Stimulus: directed part, then one random phase per register setting.
    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Phase 0 keeps the reset values; every later phase rewrites both registers
            if (ph > 0) begin
                settle_idle();
                case (ph)
                    1: begin
                        write_reg(REG_HOMING_COUNT, 16'd2);
                        write_reg(REG_BASE_OPEN, 16'd1);
                    end
                    2: begin
                        write_reg(REG_HOMING_COUNT, 16'd0);
                        write_reg(REG_BASE_OPEN, 16'd0);
                    end
                    3: begin
                        write_reg(REG_HOMING_COUNT, 16'hFFFF);
                        write_reg(REG_BASE_OPEN, 16'hFFFF);
                    end
                    4: begin
                        write_reg(REG_HOMING_COUNT, 16'd7);
                        write_reg(REG_BASE_OPEN, 16'd3);
                    end
                    5: begin
                        write_reg(REG_HOMING_COUNT, 16'($urandom_range(1, 15)));
                        write_reg(REG_BASE_OPEN, 16'($urandom_range(0, 15)));
                    end
                    6: begin
                        write_reg(REG_HOMING_COUNT, 16'($urandom));
                        write_reg(REG_BASE_OPEN, 16'($urandom_range(0, 15)));
                    end
                    default: begin
                        write_reg(REG_HOMING_COUNT, 16'($urandom_range(0, 5)));
                        write_reg(REG_BASE_OPEN, 16'($urandom));
                    end
                endcase
            end

            // Vary idling: full throttle on both sides, on one side, or random
            send_idle_max = (ph == 4 || ph == 5) ? 0 : 15;
            recv_idle_max = (ph == 4 || ph == 6) ? 0 : 15;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold off the receiver so the output stages fill and s_ready drops
                if (ph == 2 && n == 60) begin
                    hold_outputs = 1'b1;
                end
                // Pause the sender until every result is back
                if (ph == 3 && n == 120) begin
                    wait_drained();
                end
                send_item(random_item());
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run
    initial begin
        #6_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ stepper_half_step_homing_ctrl.f @@
+incdir+hw/rtl
hw/rtl/shhc_pkg.sv
hw/rtl/shhc_core.sv
hw/rtl/stepper_half_step_homing_ctrl.sv
dv/stepper_half_step_homing_ctrl_test.sv
